// ===== rtl/sorted_unique_set_table_top_macros.svh =====
// Assertion macros for the sorted set table checker.
// Self-contained; included by files that hold concurrent assertions.
`ifndef SORTED_UNIQUE_SET_TABLE_TOP_MACROS_SVH
`define SORTED_UNIQUE_SET_TABLE_TOP_MACROS_SVH

// Overlapping implication, checked on every clock edge outside reset.
`define SUST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SUST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sust_pkg.sv =====
// Shared types and constants for the sorted set table.
// No dependencies; used by controller, datapath and top level.
package sust_pkg;

   // port widths
   localparam int REQ_TYPE_W = 2;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   localparam int COUNT_W    = 7;

   // parameter defaults
   localparam int DEFAULT_CAPACITY    = 64;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INSERT   = 2'd0,
      REQ_ERASE    = 2'd1,
      REQ_CONTAINS = 2'd2,
      REQ_GET      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_INC,
      PTR_DEC,
      PTR_COUNT
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_AT_PTR,
      RD_BELOW_PTR,
      RD_ABOVE_PTR,
      RD_AT_POS
   } rd_sel_type;

   typedef enum logic {
      WR_FROM_READ,
      WR_FROM_VALUE
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef struct packed {
      logic       load;
      ptr_op_type ptr_op;
      logic       hole_capture;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       rsp_en;
      logic       rsp_success;
      logic       rsp_full;
      logic       rsp_take_read;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         ptr_at_count;
      logic         ptr_at_hole;
      logic         ptr_next_at_count;
      logic         store_full;
      logic         rd_greater;
      logic         rd_equal;
      logic         pos_valid;
   } status_type;

endpackage

// ===== rtl/sust_ctrl.sv =====
// Sequencer for the sorted set table: scan, shift and respond control.
// Depends on sust_pkg; drives the datapath only through cmd/status.
module sust_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output sust_pkg::cmd_type    cmd,
   input  sust_pkg::status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMPARE,
      ST_INS_CHK,
      ST_INS_WR,
      ST_ERA_CHK,
      ST_ERA_WR,
      ST_GET_RSP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   assign busy = busy_ff;

   always_comb begin
      cmd          = '0;
      cmd.ptr_op   = sust_pkg::PTR_HOLD;
      cmd.rd_sel   = sust_pkg::RD_AT_PTR;
      cmd.wr_sel   = sust_pkg::WR_FROM_READ;
      cmd.cnt_op   = sust_pkg::CNT_HOLD;
      state_in     = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               cmd.ptr_op = sust_pkg::PTR_ZERO;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.kind == sust_pkg::REQ_GET) begin
               if (status.pos_valid) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = sust_pkg::RD_AT_POS;
                  state_in   = ST_GET_RSP;
               end else begin
                  cmd.rsp_en = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (status.ptr_at_count) begin
               // value absent: ran off the end
               if (status.kind == sust_pkg::REQ_INSERT) begin
                  if (status.store_full) begin
                     cmd.rsp_en   = 1'b1;
                     cmd.rsp_full = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     cmd.hole_capture = 1'b1;
                     cmd.ptr_op       = sust_pkg::PTR_COUNT;
                     state_in         = ST_INS_CHK;
                  end
               end else begin
                  cmd.rsp_en = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sust_pkg::RD_AT_PTR;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.rd_greater) begin
               cmd.ptr_op = sust_pkg::PTR_INC;
               state_in   = ST_SCAN;
            end else if (status.rd_equal) begin
               unique case (status.kind) inside
                  sust_pkg::REQ_ERASE: begin
                     state_in = ST_ERA_CHK;
                  end
                  sust_pkg::REQ_CONTAINS: begin
                     cmd.rsp_en      = 1'b1;
                     cmd.rsp_success = 1'b1;
                     state_in        = ST_IDLE;
                  end
                  default: begin
                     // duplicate insert
                     cmd.rsp_en = 1'b1;
                     state_in   = ST_IDLE;
                  end
               endcase
            end else begin
               // smaller entry reached: value absent, ptr is the slot
               unique case (status.kind) inside
                  sust_pkg::REQ_INSERT: begin
                     if (status.store_full) begin
                        cmd.rsp_en   = 1'b1;
                        cmd.rsp_full = 1'b1;
                        state_in     = ST_IDLE;
                     end else begin
                        cmd.hole_capture = 1'b1;
                        cmd.ptr_op       = sust_pkg::PTR_COUNT;
                        state_in         = ST_INS_CHK;
                     end
                  end
                  sust_pkg::REQ_ERASE, sust_pkg::REQ_CONTAINS: begin
                     cmd.rsp_en = 1'b1;
                     state_in   = ST_IDLE;
                  end
                  default: begin
                     cmd.rsp_en = 1'b1;
                     state_in   = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS_CHK: begin
            if (status.ptr_at_hole) begin
               cmd.wr_en       = 1'b1;
               cmd.wr_sel      = sust_pkg::WR_FROM_VALUE;
               cmd.cnt_op      = sust_pkg::CNT_INC;
               cmd.rsp_en      = 1'b1;
               cmd.rsp_success = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sust_pkg::RD_BELOW_PTR;
               state_in   = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = sust_pkg::WR_FROM_READ;
            cmd.ptr_op = sust_pkg::PTR_DEC;
            state_in   = ST_INS_CHK;
         end
         ST_ERA_CHK: begin
            if (status.ptr_next_at_count) begin
               cmd.cnt_op      = sust_pkg::CNT_DEC;
               cmd.rsp_en      = 1'b1;
               cmd.rsp_success = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sust_pkg::RD_ABOVE_PTR;
               state_in   = ST_ERA_WR;
            end
         end
         ST_ERA_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = sust_pkg::WR_FROM_READ;
            cmd.ptr_op = sust_pkg::PTR_INC;
            state_in   = ST_ERA_CHK;
         end
         ST_GET_RSP: begin
            cmd.rsp_en        = 1'b1;
            cmd.rsp_success   = 1'b1;
            cmd.rsp_take_read = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== rtl/sust_datapath.sv =====
// Datapath of the sorted set table: value store, pointers, count, result regs.
// Depends on sust_pkg; controlled by sust_ctrl through cmd/status.
module sust_datapath #(
   parameter int CAPACITY    = sust_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = sust_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sust_pkg::cmd_type                   cmd,
   output sust_pkg::status_type                status,
   input  logic        [sust_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic signed [sust_pkg::VALUE_W-1:0]    req_value,
   input  logic        [sust_pkg::POSITION_W-1:0] req_position,
   output logic                                rsp_valid,
   output logic                                rsp_success,
   output logic                                rsp_full_refused,
   output logic signed [sust_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic        [sust_pkg::COUNT_W-1:0]    rsp_element_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > sust_pkg::POSITION_W) ? CNT_W : sust_pkg::POSITION_W;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   sust_pkg::req_kind_type kind_ff;
   logic [sust_pkg::POSITION_W-1:0] position_ff;
   logic [CNT_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       hole_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ptr_next;
   logic [CNT_W-1:0]       rd_addr_full;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   logic                           rsp_valid_ff;
   logic                           rsp_success_ff;
   logic                           rsp_full_ff;
   logic [sust_pkg::VALUE_W-1:0]   rsp_read_ff;
   logic [sust_pkg::COUNT_W-1:0]   rsp_count_ff;

   assign ptr_next = ptr_ff + ONE;

   always_comb begin
      case (cmd.ptr_op)
         sust_pkg::PTR_ZERO:  ptr_in = '0;
         sust_pkg::PTR_INC:   ptr_in = ptr_next;
         sust_pkg::PTR_DEC:   ptr_in = ptr_ff - ONE;
         sust_pkg::PTR_COUNT: ptr_in = count_ff;
         default:             ptr_in = ptr_ff;
      endcase

      case (cmd.cnt_op)
         sust_pkg::CNT_INC: count_in = count_ff + ONE;
         sust_pkg::CNT_DEC: count_in = count_ff - ONE;
         default:           count_in = count_ff;
      endcase

      case (cmd.rd_sel)
         sust_pkg::RD_BELOW_PTR: rd_addr_full = ptr_ff - ONE;
         sust_pkg::RD_ABOVE_PTR: rd_addr_full = ptr_next;
         sust_pkg::RD_AT_POS:    rd_addr_full = CNT_W'(position_ff);
         default:                rd_addr_full = ptr_ff;
      endcase
   end

   assign rd_addr = rd_addr_full[IDX_W-1:0];
   assign wr_addr = ptr_ff[IDX_W-1:0];
   assign wr_data = (cmd.wr_sel == sust_pkg::WR_FROM_VALUE) ? value_ff : rdata_ff;

   // single-port-style store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // request capture, pointers and result payload (no reset)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff    <= VALUE_WIDTH'($unsigned(req_value));
         kind_ff     <= sust_pkg::req_kind_type'(req_type);
         position_ff <= req_position;
      end
      ptr_ff <= ptr_in;
      if (cmd.hole_capture) begin
         hole_ff <= ptr_ff;
      end
      rsp_success_ff <= cmd.rsp_success;
      rsp_full_ff    <= cmd.rsp_full;
      rsp_read_ff    <= cmd.rsp_take_read ? sust_pkg::VALUE_W'(rdata_ff) : '0;
      rsp_count_ff   <= sust_pkg::COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_comb begin
      status.kind              = kind_ff;
      status.ptr_at_count      = (ptr_ff == count_ff);
      status.ptr_at_hole       = (ptr_ff == hole_ff);
      status.ptr_next_at_count = (ptr_next == count_ff);
      status.store_full        = (count_ff == CAP_COUNT);
      status.rd_greater        = ($signed(rdata_ff) > $signed(value_ff));
      status.rd_equal          = (rdata_ff == value_ff);
      status.pos_valid         = (CMP_W'(position_ff) < CMP_W'(count_ff));
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = rsp_success_ff;
   assign rsp_full_refused  = rsp_full_ff;
   assign rsp_read_value    = $signed(rsp_read_ff);
   assign rsp_element_count = rsp_count_ff;

endmodule

// ===== rtl/sorted_unique_set_table_top.sv =====
// Top level of the sorted set table: sequencer plus datapath.
// Depends on sust_pkg, sust_ctrl and sust_datapath.
//
// A set of distinct signed values kept in descending order (rank 0 is
// the largest). Each request is insert, erase, contains or get-by-rank.
// Request channel: a request is taken on a rising edge with start high
//   and busy low; req_type, req_value and req_position are sampled then.
// Result channel: exactly one result per request, shown for one cycle
//   with rsp_valid high. The receiver cannot stall; it must take it.
// Sequencing: one request in flight at a time. The store is a memory
//   with a single registered read port, so each entry compared takes a
//   read in ST_SCAN and a compare in ST_COMPARE, and each entry moved
//   takes a read in ST_INS_CHK or ST_ERA_CHK and a write in ST_INS_WR or
//   ST_ERA_WR. A get reads the entry at the rank when the rank is below
//   the count and then responds; an insert shifts the entries below its
//   slot down and writes the value into the hole; an erase shifts the
//   entries after the match up.
//   busy drops in the cycle rsp_valid is shown, so the next request can be
//   taken in that same cycle.
// Reset: synchronous, active high; clears the count and the controller.
//   Store contents are left as they are and only entries below the count
//   are ever read.
module sorted_unique_set_table_top #(
   parameter int CAPACITY    = sust_pkg::DEFAULT_CAPACITY,
   parameter int VALUE_WIDTH = sust_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic        [sust_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic signed [sust_pkg::VALUE_W-1:0]    req_value,
   input  logic        [sust_pkg::POSITION_W-1:0] req_position,
   output logic                                   rsp_valid,
   output logic                                   rsp_success,
   output logic                                   rsp_full_refused,
   output logic signed [sust_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic        [sust_pkg::COUNT_W-1:0]    rsp_element_count
);

   sust_pkg::cmd_type    cmd;
   sust_pkg::status_type status;

   // sequencer: walks the scan / shift loops one entry at a time
   sust_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // store, pointers, count and result registers
   sust_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_success       (rsp_success),
      .rsp_full_refused  (rsp_full_refused),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count)
   );

endmodule

// ===== rtl/sust_checker.sv =====
// Port-level checks for the sorted set table, bound to the top level.
// Depends on sust_pkg and sorted_unique_set_table_top_macros.svh.
`include "sorted_unique_set_table_top_macros.svh"

module sust_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_valid,
   input logic                                   rsp_success,
   input logic                                   rsp_full_refused,
   input logic signed [sust_pkg::VALUE_W-1:0]    rsp_read_value
);

   // a taken request always raises busy in the next cycle
   `SUST_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")

   // results only come out of a request in progress, and free the block
   `SUST_ASSERT_IMP(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy) && !busy, "stray rsp")

   // a refused insert never reports success
   `SUST_ASSERT_IMP(a_full_no_ok, clock, reset, rsp_valid && rsp_full_refused, !rsp_success, "full+ok")

   // read data is zero on every failed request
   `SUST_ASSERT_IMP(a_read_zero, clock, reset, rsp_valid && (rsp_read_value != 0), rsp_success, "rd")

endmodule

bind sorted_unique_set_table_top sust_checker u_sust_checker (.*);
